// ===== src/sdcp_pkg.sv =====
// Shared types, codes and tables for the DSP command port.
package sdcp_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 15;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);

    // Host access codes
    localparam logic [3:0] ACT_RESET_WR  = 4'd0;
    localparam logic [3:0] ACT_RESET_RD  = 4'd1;
    localparam logic [3:0] ACT_CMD_WR    = 4'd2;
    localparam logic [3:0] ACT_WSTAT_RD  = 4'd3;
    localparam logic [3:0] ACT_DATA_RD   = 4'd4;
    localparam logic [3:0] ACT_DATA_WR   = 4'd5;
    localparam logic [3:0] ACT_RSTAT_RD  = 4'd6;
    localparam logic [3:0] ACT_RSTAT_WR  = 4'd7;
    localparam logic [3:0] ACT_DACK_RD   = 4'd8;
    localparam logic [3:0] ACT_DACK_WR   = 4'd9;

    // DSP opcodes
    localparam logic [7:0] OP_NOP10      = 8'h10;
    localparam logic [7:0] OP_DMA_START  = 8'h14;
    localparam logic [7:0] OP_NOP40      = 8'h40;
    localparam logic [7:0] OP_DMA_LEN    = 8'h48;
    localparam logic [7:0] OP_SPK_ON     = 8'hD1;
    localparam logic [7:0] OP_SPK_OFF    = 8'hD3;
    localparam logic [7:0] OP_SPK_STAT   = 8'hD8;
    localparam logic [7:0] OP_IDENT      = 8'hE0;
    localparam logic [7:0] OP_VERSION    = 8'hE1;
    localparam logic [7:0] OP_GUARD      = 8'hE2;
    localparam logic [7:0] OP_TEST_WR    = 8'hE4;
    localparam logic [7:0] OP_TEST_RD    = 8'hE8;
    localparam logic [7:0] OP_IRQ        = 8'hF2;
    localparam logic [7:0] OP_ZERO_REPLY = 8'hF8;

    // Fixed bytes
    localparam logic [7:0] RESET_REPLY   = 8'hAA;
    localparam logic [7:0] GUARD_INIT    = 8'hAA;
    localparam logic [7:0] UNMAPPED_BYTE = 8'hFF;
    localparam logic [7:0] RSTAT_READY   = 8'h80;
    localparam logic [16:0] XFER_MAX     = 17'h1FFFF;

    // Guard weights, modulo 256; last column is the row constant
    localparam logic [7:0] GUARD_W [4][9] = '{
        '{8'h01, 8'hFE, 8'hFC, 8'h08, 8'hF0, 8'h20, 8'h40, 8'h80, 8'h96},
        '{8'hFF, 8'h02, 8'hFC, 8'h08, 8'h10, 8'hE0, 8'h40, 8'h80, 8'hA5},
        '{8'hFF, 8'h02, 8'h04, 8'hF8, 8'h10, 8'hE0, 8'hC0, 8'h80, 8'h69},
        '{8'h01, 8'hFE, 8'h04, 8'hF8, 8'hF0, 8'h20, 8'hC0, 8'h80, 8'h5A}
    };

    typedef struct packed {
        logic [3:0] action;
        logic       port_offset;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       dma_request;
        logic       interrupt_request;
    } out_item_t;

    // Command length in bytes; zero for an unknown opcode
    function automatic logic [1:0] opcode_length(input logic [7:0] op);
        logic [1:0] len;
        unique case (op)
            OP_SPK_ON, OP_SPK_OFF, OP_SPK_STAT, OP_VERSION,
            OP_TEST_RD, OP_IRQ, OP_ZERO_REPLY:            len = 2'd1;
            OP_NOP10, OP_NOP40, OP_IDENT, OP_GUARD,
            OP_TEST_WR:                                   len = 2'd2;
            OP_DMA_START, OP_DMA_LEN:                     len = 2'd3;
            default:                                      len = 2'd0;
        endcase
        return len;
    endfunction

    // Sum of the row weights selected by the parameter bits plus row constant
    function automatic logic [7:0] guard_delta(input logic [1:0] row,
                                               input logic [7:0] p);
        logic [7:0] acc;
        acc = GUARD_W[row][8];
        for (int i = 0; i < 8; i++)
        begin
            if (p[i])
            begin
                acc = acc + GUARD_W[row][i];
            end
        end
        return acc;
    endfunction

endpackage

// ===== src/sdcp_core.sv =====
// DSP state: command and reply queues, command execution, DMA and IRQ levels.
module sdcp_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  sdcp_pkg::in_item_t  item,
    input  logic [15:0]         version,
    output sdcp_pkg::out_item_t result
);

    localparam logic [sdcp_pkg::CNT_W-1:0] DEPTH_C =
        sdcp_pkg::CNT_W'(sdcp_pkg::QUEUE_DEPTH);

    logic [7:0]                 cq_reg   [sdcp_pkg::QUEUE_DEPTH];
    logic [7:0]                 cq_next  [sdcp_pkg::QUEUE_DEPTH];
    logic [7:0]                 rq_reg   [sdcp_pkg::QUEUE_DEPTH];
    logic [7:0]                 rq_next  [sdcp_pkg::QUEUE_DEPTH];
    logic [sdcp_pkg::CNT_W-1:0] ccnt_reg, ccnt_next;
    logic [sdcp_pkg::CNT_W-1:0] rcnt_reg, rcnt_next;
    logic                       rready_reg, rready_next;
    logic [7:0]                 latch_reg, latch_next;
    logic [7:0]                 tval_reg, tval_next;
    logic                       spk_reg, spk_next;
    logic [16:0]                xlen_reg, xlen_next;
    logic [16:0]                xdone_reg, xdone_next;
    logic [7:0]                 guard_reg, guard_next;
    logic [1:0]                 phase_reg, phase_next;
    logic [7:0]                 ack_reg, ack_next;
    logic                       drq_reg, drq_next;
    logic                       irq_reg, irq_next;

    logic [7:0] rd;
    logic [7:0] op;
    logic [1:0] op_len;
    logic [1:0] push_n;
    logic [7:0] push_b [2];
    logic       odd;

    assign odd = item.port_offset;

    // Work out the next state and the read byte for one request
    always_comb
    begin
        cq_next     = cq_reg;
        rq_next     = rq_reg;
        ccnt_next   = ccnt_reg;
        rcnt_next   = rcnt_reg;
        rready_next = rready_reg;
        latch_next  = latch_reg;
        tval_next   = tval_reg;
        spk_next    = spk_reg;
        xlen_next   = xlen_reg;
        xdone_next  = xdone_reg;
        guard_next  = guard_reg;
        phase_next  = phase_reg;
        ack_next    = ack_reg;
        drq_next    = drq_reg;
        irq_next    = irq_reg;
        rd          = 8'h00;
        op          = 8'h00;
        op_len      = 2'd0;
        push_n      = 2'd0;
        push_b[0]   = 8'h00;
        push_b[1]   = 8'h00;

        if (fire)
        begin
            unique case (item.action)
                sdcp_pkg::ACT_RESET_WR:
                begin
                    if (!odd)
                    begin
                        // One then zero: empty both queues and queue the reset reply
                        if (item.data_byte == 8'h00 && latch_reg == 8'h01)
                        begin
                            ccnt_next   = '0;
                            rq_next[0]  = sdcp_pkg::RESET_REPLY;
                            rcnt_next   = sdcp_pkg::CNT_W'(1);
                            rready_next = 1'b1;
                        end
                        latch_next = item.data_byte;
                    end
                end
                sdcp_pkg::ACT_RESET_RD:
                begin
                    rd = sdcp_pkg::UNMAPPED_BYTE;
                end
                sdcp_pkg::ACT_CMD_WR:
                begin
                    if (!odd)
                    begin
                        // Append the byte, drop it when the queue is full
                        if (ccnt_reg < DEPTH_C)
                        begin
                            cq_next[ccnt_reg[sdcp_pkg::IDX_W-1:0]] = item.data_byte;
                            ccnt_next = ccnt_reg + 1'b1;
                        end
                        op     = cq_next[0];
                        op_len = sdcp_pkg::opcode_length(op);
                        if (op_len != 2'd0 && ccnt_next == sdcp_pkg::CNT_W'(op_len))
                        begin
                            ccnt_next = '0;
                            unique case (op)
                                sdcp_pkg::OP_DMA_START:
                                begin
                                    xlen_next  = {1'b0, cq_next[2], cq_next[1]} + 17'd1;
                                    xdone_next = '0;
                                    drq_next   = 1'b1;
                                end
                                sdcp_pkg::OP_DMA_LEN:
                                begin
                                    xlen_next = {1'b0, cq_next[2], cq_next[1]} + 17'd1;
                                end
                                sdcp_pkg::OP_SPK_ON:  spk_next = 1'b1;
                                sdcp_pkg::OP_SPK_OFF: spk_next = 1'b0;
                                sdcp_pkg::OP_SPK_STAT:
                                begin
                                    push_n    = 2'd1;
                                    push_b[0] = spk_reg ? 8'hFF : 8'h00;
                                end
                                sdcp_pkg::OP_IDENT:
                                begin
                                    push_n    = 2'd1;
                                    push_b[0] = ~cq_next[1];
                                end
                                sdcp_pkg::OP_VERSION:
                                begin
                                    push_n    = 2'd2;
                                    push_b[0] = version[15:8];
                                    push_b[1] = version[7:0];
                                end
                                sdcp_pkg::OP_GUARD:
                                begin
                                    guard_next = guard_reg
                                               + sdcp_pkg::guard_delta(phase_reg, cq_next[1]);
                                    phase_next = phase_reg + 2'd1;
                                    ack_next   = guard_next;
                                    drq_next   = 1'b1;
                                end
                                sdcp_pkg::OP_TEST_WR: tval_next = cq_next[1];
                                sdcp_pkg::OP_TEST_RD:
                                begin
                                    push_n    = 2'd1;
                                    push_b[0] = tval_reg;
                                end
                                sdcp_pkg::OP_IRQ: irq_next = 1'b1;
                                sdcp_pkg::OP_ZERO_REPLY:
                                begin
                                    push_n    = 2'd1;
                                    push_b[0] = 8'h00;
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                sdcp_pkg::ACT_WSTAT_RD:
                begin
                    rd = odd ? sdcp_pkg::UNMAPPED_BYTE : 8'h00;
                end
                sdcp_pkg::ACT_DATA_RD:
                begin
                    if (odd)
                    begin
                        rd = sdcp_pkg::UNMAPPED_BYTE;
                    end
                    else
                    begin
                        // Pop the head of the reply queue
                        if (rcnt_reg != '0)
                        begin
                            rd = rq_reg[0];
                            for (int i = 0; i < sdcp_pkg::QUEUE_DEPTH - 1; i++)
                            begin
                                rq_next[i] = rq_reg[i + 1];
                            end
                            rq_next[sdcp_pkg::QUEUE_DEPTH - 1] = 8'h00;
                            rcnt_next = rcnt_reg - 1'b1;
                        end
                        if (rcnt_next == '0)
                        begin
                            rready_next = 1'b0;
                        end
                    end
                end
                sdcp_pkg::ACT_RSTAT_RD:
                begin
                    irq_next = 1'b0;
                    if (odd)
                    begin
                        rd = sdcp_pkg::UNMAPPED_BYTE;
                    end
                    else
                    begin
                        rd = rready_reg ? sdcp_pkg::RSTAT_READY : 8'h00;
                    end
                end
                sdcp_pkg::ACT_DACK_RD:
                begin
                    drq_next = 1'b0;
                    rd       = ack_reg;
                end
                sdcp_pkg::ACT_DACK_WR:
                begin
                    // Count the transfer, saturating; finish when length reached
                    if (xdone_reg != sdcp_pkg::XFER_MAX)
                    begin
                        xdone_next = xdone_reg + 17'd1;
                    end
                    if (xdone_next >= xlen_reg)
                    begin
                        drq_next = 1'b0;
                        irq_next = 1'b1;
                    end
                end
                default: ;
            endcase

            // Queue reply bytes; a full queue drops them but still flags ready
            for (int k = 0; k < 2; k++)
            begin
                if (push_n > 2'(k))
                begin
                    rready_next = 1'b1;
                    if (rcnt_next < DEPTH_C)
                    begin
                        rq_next[rcnt_next[sdcp_pkg::IDX_W-1:0]] = push_b[k];
                        rcnt_next = rcnt_next + 1'b1;
                    end
                end
            end
        end
    end

    assign result.read_data         = rd;
    assign result.dma_request       = drq_next;
    assign result.interrupt_request = irq_next;

    // Hold the DSP state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sdcp_pkg::QUEUE_DEPTH; i++)
            begin
                cq_reg[i] <= 8'h00;
                rq_reg[i] <= 8'h00;
            end
            ccnt_reg   <= '0;
            rcnt_reg   <= '0;
            rready_reg <= 1'b0;
            latch_reg  <= 8'h00;
            tval_reg   <= 8'h00;
            spk_reg    <= 1'b0;
            xlen_reg   <= '0;
            xdone_reg  <= '0;
            guard_reg  <= sdcp_pkg::GUARD_INIT;
            phase_reg  <= 2'd0;
            ack_reg    <= 8'h00;
            drq_reg    <= 1'b0;
            irq_reg    <= 1'b0;
        end
        else
        begin
            cq_reg     <= cq_next;
            rq_reg     <= rq_next;
            ccnt_reg   <= ccnt_next;
            rcnt_reg   <= rcnt_next;
            rready_reg <= rready_next;
            latch_reg  <= latch_next;
            tval_reg   <= tval_next;
            spk_reg    <= spk_next;
            xlen_reg   <= xlen_next;
            xdone_reg  <= xdone_next;
            guard_reg  <= guard_next;
            phase_reg  <= phase_next;
            ack_reg    <= ack_next;
            drq_reg    <= drq_next;
            irq_reg    <= irq_next;
        end
    end

endmodule

// ===== src/sound_dsp_command_port_top.sv =====
// Top level of the DSP command port: request register, result register, version register.
//
// Each request is one host port access or DMA acknowledge; it returns one result with the
// byte read and the DRQ and IRQ levels after the access. A request is held in the request
// register, is applied to the DSP state in a single pass and lands in the result register,
// so a new request can be taken every cycle; requests only stall while a result waits on
// out_ready with the request register also full. The version word is written through the
// cfg channel, which is always ready; the user must write it only while no request is in
// flight, as the block itself does not enforce this.
module sound_dsp_command_port_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sdcp_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output sdcp_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data
);

    sdcp_pkg::in_item_t  req_reg;
    logic                req_full_reg;
    sdcp_pkg::out_item_t res_reg;
    logic                res_valid_reg;
    logic [15:0]         version_reg;
    sdcp_pkg::out_item_t core_result;
    logic                advance;
    logic                fire;

    // Move the request forward when the result slot is free or being taken
    assign advance   = !res_valid_reg || out_ready;
    assign fire      = advance && req_full_reg;
    assign in_ready  = !req_full_reg || advance;
    assign cfg_ready = 1'b1;
    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

    sdcp_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .item    (req_reg),
        .version (version_reg),
        .result  (core_result)
    );

    // Hold request and result control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_full_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            version_reg   <= 16'h0105;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                req_full_reg <= 1'b1;
            end
            else if (advance)
            begin
                req_full_reg <= 1'b0;
            end
            if (advance)
            begin
                res_valid_reg <= req_full_reg;
            end
            if (cfg_valid && cfg_ready)
            begin
                version_reg <= cfg_data;
            end
        end
    end

    // Capture payloads
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= in_data;
        end
        if (fire)
        begin
            res_reg <= core_result;
        end
    end

endmodule

// ===== src/sdcp_checker.sv =====
// Port-level checks for the DSP command port, bound to the top level.
module sdcp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input sdcp_pkg::out_item_t out_data
);

    // A stalled result stays
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result changed while stalled");

    // Requests stall only behind a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("request stalled without output backpressure");

    // No result right out of reset
    assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid out of reset");

endmodule

bind sound_dsp_command_port_top sdcp_checker u_sdcp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
